// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst, cond) \
  `ASSERT_ALWAYS(name, clk, rst, !(cond))

`else

`define ASSERT_ALWAYS(name, clk, rst, prop)

`define ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

// ----- hw/rtl/lap3_pkg.sv -----
// shared constants and types for the laplacian filter
package lap3_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int BORDER     = 2;
  localparam int NRES       = 4;
  localparam int MIN_DIM    = 5;
  localparam int LAP_W      = PIX_W + 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // result slots in emission order
  localparam int RES_CENTER = 0;
  localparam int RES_RIGHT  = 1;
  localparam int RES_BELOW  = 2;
  localparam int RES_CORNER = 3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] up2;
    logic [PIX_W-1:0] up1;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [NRES-1:0]  mask;
    logic             inner;
  } job_t;

endpackage

// ----- hw/rtl/laplacian_3x3_clamped_filter.sv -----
// top level: configuration, raster counters, line ram and pipeline control
// Streaming 3x3 eight-neighbour Laplacian over 8-bit pixels in raster order. One pixel
// beat is taken per clock while out_ready keeps up; inside a row each pixel yields at most
// one result. The single output register emits one result per cycle while out_ready is
// high; the last column of a row and each pixel of the last row give up to two results,
// the final pixel of a frame four, and the input waits meanwhile. A result passes the line
// ram read, the window/sequencer and the output register in turn. The two previous rows
// live in one 2048 x 16 synchronous ram, read when a pixel is taken and written back as
// the pixel moves on to the window. image_width is clamped to 5..2048, image_height to at
// least 5. The user must write configuration only while the block is idle; it is unchecked.
`include "assert_macros.svh"

module laplacian_3x3_clamped_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lap3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lap3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lap3_pkg::PIX_W-1:0]     pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lap3_pkg::PIX_W-1:0]     out_pixel,
  output logic [lap3_pkg::ROW_W-1:0]     out_row,
  output logic [lap3_pkg::COL_W-1:0]     out_col,
  output logic                           last_of_run,
  output logic                           frame_done
);
  import lap3_pkg::*;

  logic [COL_W-1:0]   wlast;
  logic [ROW_W-1:0]   hlast;
  logic [ROW_W-1:0]   row_count;
  logic [COL_W-1:0]   col_count;

  logic [2*PIX_W-1:0] line_ram [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pixel;
  logic [ROW_W-1:0]   s1_row;
  logic [COL_W-1:0]   s1_col;
  logic [NRES-1:0]    s1_mask;
  logic               s1_inner;
  logic               s1_adv;

  logic               accept;
  logic               last_col;
  logic               last_row;
  logic               r_ge1;
  logic               c_ge1;
  logic [NRES-1:0]    mask;
  logic               inner;
  logic               job_ready;
  job_t               job;

  assign cfg_ready = 1'b1;

  // store last column and last row indexes of the clamped geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      wlast <= COL_W'(WIDTH_RESET - CFG_W'(1));
      hlast <= HEIGHT_RESET - ROW_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_data < CFG_W'(MIN_DIM)) begin
            wlast <= COL_W'(MIN_DIM - 1);
          end else if (cfg_data > CFG_W'(MAX_WIDTH)) begin
            wlast <= COL_W'(MAX_WIDTH - 1);
          end else begin
            wlast <= COL_W'(cfg_data - CFG_W'(1));
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data < CFG_W'(MIN_DIM)) begin
            hlast <= ROW_W'(MIN_DIM - 1);
          end else begin
            hlast <= ROW_W'(cfg_data - CFG_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign s1_adv   = s1_valid && job_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  assign last_col = col_count >= wlast;
  assign last_row = row_count >= hlast;
  assign r_ge1    = row_count != '0;
  assign c_ge1    = col_count != '0;
  assign inner    = (row_count >= ROW_W'(BORDER + 1)) && (row_count < hlast) &&
                    (col_count >= COL_W'(BORDER + 1)) && (col_count < wlast);

  always_comb begin
    mask             = '0;
    mask[RES_CENTER] = r_ge1 && c_ge1;
    mask[RES_RIGHT]  = r_ge1 && last_col;
    mask[RES_BELOW]  = last_row && c_ge1;
    mask[RES_CORNER] = last_row && last_col;
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // line ram: upper byte older row, lower byte newer row
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_ram[col_count[ADDR_W-1:0]];
    end
    if (s1_adv) begin
      line_ram[s1_col[ADDR_W-1:0]] <= {rd_data[PIX_W-1:0], s1_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_row   <= row_count;
      s1_col   <= col_count;
      s1_mask  <= mask;
      s1_inner <= inner;
    end
  end

  always_comb begin
    job.pixel = s1_pixel;
    job.up2   = rd_data[2*PIX_W-1:PIX_W];
    job.up1   = rd_data[PIX_W-1:0];
    job.row   = s1_row;
    job.col   = s1_col;
    job.mask  = s1_mask;
    job.inner = s1_inner;
  end

  lap3_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (s1_valid),
    .job_ready   (job_ready),
    .job         (job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel   (out_pixel),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

  `ASSERT_ALWAYS(a_rdata_held, clk, rst, s1_valid && !s1_adv |=> (rd_data === $past(rd_data)))
  `ASSERT_NEVER(a_ram_collide, clk, rst,
    accept && s1_adv && (s1_col[ADDR_W-1:0] == col_count[ADDR_W-1:0]))
  `ASSERT_ALWAYS(a_take_loads, clk, rst, accept |=> s1_valid)

endmodule

// ----- hw/rtl/lap3_emit.sv -----
// window registers, laplacian kernel and result sequencer with output register
`include "assert_macros.svh"

module lap3_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  lap3_pkg::job_t             job,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lap3_pkg::PIX_W-1:0] out_pixel,
  output logic [lap3_pkg::ROW_W-1:0] out_row,
  output logic [lap3_pkg::COL_W-1:0] out_col,
  output logic                       last_of_run,
  output logic                       frame_done
);
  import lap3_pkg::*;

  logic [PIX_W-1:0] win [9];
  logic [NRES-1:0]  pend;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             inner;

  logic [NRES-1:0]  low_bit;
  logic [NRES-1:0]  pend_next;
  logic             take;
  logic             load;
  logic [LAP_W-1:0] nsum;
  logic [LAP_W-1:0] ctr8;
  logic [LAP_W-1:0] diff;
  logic [PIX_W-1:0] lap;
  logic [PIX_W-1:0] sel_pixel;
  logic [ROW_W-1:0] sel_row;
  logic [COL_W-1:0] sel_col;
  logic             sel_done;

  assign low_bit   = pend & (~pend + NRES'(1));
  assign pend_next = pend & ~low_bit;
  assign take      = (pend != '0) && (!out_valid || out_ready);
  assign job_ready = (pend == '0) || (take && (pend_next == '0));
  assign load      = job_valid && job_ready;

  // eight-neighbour kernel, clamped to pixel range
  always_comb begin
    nsum = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        nsum = nsum + LAP_W'(win[k]);
      end
    end
    ctr8 = {win[4], 3'b000};
    diff = ctr8 - nsum;
    if (nsum > ctr8) begin
      lap = '0;
    end else if (diff > LAP_W'(255)) begin
      lap = '1;
    end else begin
      lap = diff[PIX_W-1:0];
    end
  end

  always_comb begin
    sel_pixel = win[8];
    sel_row   = row;
    sel_col   = col;
    sel_done  = 1'b0;
    if (pend[RES_CENTER]) begin
      sel_pixel = inner ? lap : win[4];
      sel_row   = row - ROW_W'(1);
      sel_col   = col - COL_W'(1);
    end else if (pend[RES_RIGHT]) begin
      sel_pixel = win[5];
      sel_row   = row - ROW_W'(1);
    end else if (pend[RES_BELOW]) begin
      sel_pixel = win[7];
      sel_col   = col - COL_W'(1);
    end else begin
      sel_done  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (load) begin
      pend <= job.mask;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= job.up2;
      win[5] <= job.up1;
      win[8] <= job.pixel;
    end else if (take) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row   <= job.row;
      col   <= job.col;
      inner <= job.inner;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pixel   <= sel_pixel;
      out_row     <= sel_row;
      out_col     <= sel_col;
      last_of_run <= (pend_next == '0);
      frame_done  <= sel_done;
    end
  end

  `ASSERT_ALWAYS(a_done_is_last, clk, rst, out_valid && frame_done |-> last_of_run)
  `ASSERT_ALWAYS(a_pend_shrinks, clk, rst,
    (pend != '0) && !load |=> ((pend & ~$past(pend)) == '0))
  `ASSERT_ALWAYS(a_take_fills, clk, rst, take |=> out_valid)

endmodule
